/* hw/rtl/ssc_pkg.sv */
package ssc_pkg;

    localparam int TEXT_W      = 8;
    localparam int OUT_COUNT_W = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_REG_W   = 5;
    localparam int REG_BYTES   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_MODE = 2'd3;

    localparam logic [TEXT_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [TEXT_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [TEXT_W-1:0] CASE_OFFSET = 8'h20;

    // Only the letters A to Z are folded; every other byte passes unchanged.
    function automatic logic [TEXT_W-1:0] fold_byte(input logic [TEXT_W-1:0] c);
        logic [TEXT_W-1:0] folded;
        folded = c;
        if (c inside {[UPPER_FIRST:UPPER_LAST]})
        begin
            folded = c + CASE_OFFSET;
        end
        return folded;
    endfunction

endpackage

/* hw/rtl/ssc_in_if.sv */
interface ssc_in_if
    import ssc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* hw/rtl/ssc_out_if.sv */
interface ssc_out_if
    import ssc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   match_here;
    logic [OUT_COUNT_W-1:0] match_count;
    logic                   count_final;

    modport source (output valid, output match_here, output match_count,
                    output count_final, input ready);
    modport sink   (input valid, input match_here, input match_count,
                    input count_final, output ready);
endinterface

/* hw/rtl/ssc_cfg.sv */
module ssc_cfg
    import ssc_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [TEXT_W-1:0]     pattern [MAX_PATTERN],
    output logic [LEN_W-1:0]      pat_len,
    output logic                  overlap
);

    logic [TEXT_W-1:0]    pattern_reg [MAX_PATTERN];
    logic [LEN_REG_W-1:0] len_reg;
    logic                 overlap_reg;

    // Pattern bytes are stored already folded, so the compare sees folded values only.
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_pat
        localparam logic [CFG_IDX_W-1:0] WORD_IDX =
            (k < REG_BYTES) ? CFG_PATTERN_LOW : CFG_PATTERN_HIGH;
        localparam int BIT_POS = TEXT_W * (k % REG_BYTES);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[k] <= '0;
            end
            else if (cfg_we && cfg_index == WORD_IDX)
            begin
                pattern_reg[k] <= fold_byte(cfg_data[BIT_POS +: TEXT_W]);
            end
        end

        assign pattern[k] = pattern_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_REG_W'(1);
            overlap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LEN:  len_reg     <= cfg_data[LEN_REG_W-1:0];
                CFG_OVERLAP_MODE: overlap_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (len_reg == '0)
        begin
            pat_len = LEN_W'(1);
        end
        else if (len_reg > LEN_REG_W'(MAX_PATTERN))
        begin
            pat_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            pat_len = LEN_W'(len_reg);
        end
    end

    assign overlap = overlap_reg;

endmodule

/* hw/rtl/ssc_core.sv */
module ssc_core
    import ssc_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    ssc_in_if.sink            text_in,
    ssc_out_if.source         result_out,
    input  logic [TEXT_W-1:0] pattern [MAX_PATTERN],
    input  logic [LEN_W-1:0]  pat_len,
    input  logic              overlap
);

    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int EXT_W  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(MAX_PATTERN);

    // Input register.
    logic              s1_valid_reg;
    logic [TEXT_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // String state.
    logic [TEXT_W-1:0]     window_reg [MAX_PATTERN];
    logic [TEXT_W-1:0]     window_next [MAX_PATTERN];
    logic [LEN_W-1:0]      start_reg;
    logic [LEN_W-1:0]      start_next;
    logic [LEN_W-1:0]      since_match_reg;
    logic [LEN_W-1:0]      since_match_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   match_here_reg;
    logic [OUT_COUNT_W-1:0] match_count_reg;
    logic                   count_final_reg;

    logic                   out_free;
    logic                   advance;
    logic [LEN_W-1:0]       start_inc;
    logic [LEN_W-1:0]       since_inc;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic                   hit;
    logic [EXT_W-1:0]       total_ext;

    assign out_free      = !out_valid_reg || result_out.ready;
    assign advance       = s1_valid_reg && out_free;
    assign text_in.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            s1_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            s1_byte_reg <= fold_byte(text_in.text_byte);
            s1_last_reg <= text_in.end_of_text;
        end
    end

    // Window lanes older than the current string are never compared, because a
    // match needs at least pat_len bytes of this string, so the window is not cleared.
    always_comb
    begin
        window_next[0] = s1_byte_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i-1];
        end

        start_inc = (start_reg == LEN_MAX) ? start_reg : start_reg + LEN_W'(1);
        since_inc = (since_match_reg == LEN_MAX) ? since_match_reg
                                                 : since_match_reg + LEN_W'(1);

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            lane_ok[i] = (LEN_W'(i) >= pat_len) ||
                         (window_next[i] ==
                          pattern[PIDX_W'(pat_len - LEN_W'(i) - LEN_W'(1))]);
        end

        hit = (start_inc >= pat_len) && (&lane_ok) &&
              !(!overlap && since_inc < pat_len);

        total_next = (hit && total_reg != COUNT_MAX) ? total_reg + COUNT_BITS'(1)
                                                     : total_reg;
        since_match_next = hit ? '0 : since_inc;
        start_next       = start_inc;

        if (s1_last_reg)
        begin
            start_next       = '0;
            since_match_next = LEN_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg       <= '0;
            since_match_reg <= LEN_MAX;
            total_reg       <= '0;
        end
        else if (advance)
        begin
            start_reg       <= start_next;
            since_match_reg <= since_match_next;
            total_reg       <= s1_last_reg ? '0 : total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    assign total_ext = EXT_W'(total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            match_here_reg  <= hit;
            match_count_reg <= total_ext[OUT_COUNT_W-1:0];
            count_final_reg <= s1_last_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.match_here  = match_here_reg;
    assign result_out.match_count = match_count_reg;
    assign result_out.count_final = count_final_reg;

endmodule

/* hw/rtl/substring_occurrence_counter.sv */
// Case-insensitive substring counter over a byte stream.
// text_in carries one text byte per transaction, with end_of_text on the last
// byte of a string. result_out returns one transaction per text byte: whether a
// counted match ends at that byte, the running count of the string, and
// count_final on the last byte. The pattern, its length and the overlap mode
// are set through the cfg_we / cfg_index / cfg_data write port; the user sets
// them between strings, which the block itself does not enforce. Each byte
// passes the input register, then the window compare into the result register.
// Throughput is one byte per cycle while result_out takes results; the parallel
// compare of all window lanes against the pattern fits between the two registers.
// A stalled result_out holds the result register; the input register still
// takes one more byte, and text_in.ready drops only when both are full.
// Reset empties both registers, clears the string state and loads the default
// configuration: an all-zero pattern, length one, overlapping counting.
// After the byte marked end_of_text the string state clears by itself.
module substring_occurrence_counter
    import ssc_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ssc_in_if.sink                text_in,
    ssc_out_if.source             result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [TEXT_W-1:0] pattern [MAX_PATTERN];
    logic [LEN_W-1:0]  pat_len;
    logic              overlap;

    ssc_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern),
        .pat_len   (pat_len),
        .overlap   (overlap)
    );

    ssc_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out),
        .pattern    (pattern),
        .pat_len    (pat_len),
        .overlap    (overlap)
    );

endmodule

/* hw/rtl/ssc_checker.sv */
module ssc_checker
    import ssc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   match_here,
    input logic [OUT_COUNT_W-1:0] match_count
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction withdrawn while stalled");

    // With the result register empty the input side can always move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("text input stalled while result register is empty");

    // A counted match leaves a nonzero count when the count fits the field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_BITS <= OUT_COUNT_W) && out_valid && match_here |-> match_count != '0)
        else $error("match reported with a zero count");

    // Reset empties the result register.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // No result appears in the cycle right after reset with no input before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind substring_occurrence_counter ssc_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_ssc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (text_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .match_here  (result_out.match_here),
    .match_count (result_out.match_count)
);

/* tb/substring_occurrence_counter_tb.sv */
module substring_occurrence_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    localparam int MAX_LEN        = 16;
    localparam int IDLE_PCT       = 17;
    localparam int RANDOM_BYTES   = 450;
    localparam int LONG_RUN_BYTES = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_CYCLES     = 1000000;

    typedef struct packed {
        logic                   hit;
        logic [OUT_COUNT_W-1:0] count;
        logic                   last;
    } count_result_t;

    class match_scoreboard;
        logic [CFG_DATA_W-1:0]  pat_low;
        logic [CFG_DATA_W-1:0]  pat_high;
        logic [LEN_REG_W-1:0]   pat_len;
        logic                   overlap;
        logic [TEXT_W-1:0]      window [MAX_LEN];
        int                     seen;
        int                     since_match;
        logic [OUT_COUNT_W-1:0] total;
        count_result_t          expected [$];
        int                     errors;
        int                     results;
        int                     hits;
        int                     strings;
        bit                     saturated;

        function new();
            pat_low = '0;
            pat_high = '0;
            pat_len = LEN_REG_W'(1);
            overlap = 1'b1;
            errors = 0;
            results = 0;
            hits = 0;
            strings = 0;
            saturated = 1'b0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[i])
            begin
                window[i] = '0;
            end
            seen = 0;
            since_match = MAX_LEN;
            total = '0;
        endfunction

        function logic [TEXT_W-1:0] fold_case(input logic [TEXT_W-1:0] c);
            if (c >= UPPER_FIRST && c <= UPPER_LAST)
            begin
                return c + CASE_OFFSET;
            end
            return c;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_LOW:  pat_low = data;
                CFG_PATTERN_HIGH: pat_high = data;
                CFG_PATTERN_LEN:  pat_len = data[LEN_REG_W-1:0];
                CFG_OVERLAP_MODE: overlap = data[0];
                default: ;
            endcase
        endfunction

        function void note_byte(input logic [TEXT_W-1:0] b, input logic eot);
            logic [2*CFG_DATA_W-1:0] pat;
            int                      len;
            int                      i;
            count_result_t           r;
            pat = {pat_high, pat_low};
            len = (pat_len == 0) ? 1 : ((pat_len > MAX_LEN) ? MAX_LEN : int'(pat_len));
            for (i = MAX_LEN - 1; i > 0; i--)
            begin
                window[i] = window[i-1];
            end
            window[0] = b;
            if (seen < MAX_LEN)
            begin
                seen++;
            end
            if (since_match < MAX_LEN)
            begin
                since_match++;
            end
            r.hit = (seen >= len);
            for (i = 0; i < len; i++)
            begin
                if (fold_case(window[i]) != fold_case(pat[(len-1-i)*TEXT_W +: TEXT_W]))
                begin
                    r.hit = 1'b0;
                end
            end
            // Without overlap, a match must start after the last counted one ended.
            if (r.hit && !overlap && since_match < len)
            begin
                r.hit = 1'b0;
            end
            if (r.hit)
            begin
                since_match = 0;
                hits++;
                if (total != '1)
                begin
                    total++;
                end
                if (total == '1)
                begin
                    saturated = 1'b1;
                end
            end
            r.count = total;
            r.last = eot;
            expected.push_back(r);
            if (eot)
            begin
                strings++;
                clear_string();
            end
        endfunction

        function void check_result(input logic hit, input logic [OUT_COUNT_W-1:0] count,
                                   input logic last);
            count_result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual match_here=%0b %s%0d %s%0b",
                         $time, hit, "match_count=", count, "count_final=", last);
                errors++;
            end
            else
            begin
                want = expected.pop_front();
                results++;
                if (hit !== want.hit)
                begin
                    $display("%0t: match_here expected %0b, actual %0b", $time, want.hit, hit);
                    errors++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: match_count expected %0d, actual %0d",
                             $time, want.count, count);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: count_final expected %0b, actual %0b",
                             $time, want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;
    int unsigned           cycle_count = 0;
    int unsigned           random_bytes;
    int unsigned           settings;
    logic [TEXT_W-1:0]     pattern [MAX_LEN];
    int unsigned           pattern_size;
    logic [TEXT_W-1:0]     text_buf [$];
    match_scoreboard       sb;

    ssc_in_if  text_in();
    ssc_out_if result_out();

    substring_occurrence_counter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            sb.check_result(result_out.match_here, result_out.match_count,
                            result_out.count_final);
        end
    end

    function automatic logic [TEXT_W-1:0] random_char();
        case ($urandom_range(7))
            0, 1, 2: return TEXT_W'(UPPER_FIRST + CASE_OFFSET + $urandom_range(2));
            3, 4:    return TEXT_W'(UPPER_FIRST + $urandom_range(2));
            5:
            begin
                case ($urandom_range(5))
                    0:       return TEXT_W'(UPPER_FIRST - 1);
                    1:       return UPPER_LAST;
                    2:       return TEXT_W'(UPPER_LAST + 1);
                    3:       return TEXT_W'(UPPER_FIRST + CASE_OFFSET - 1);
                    4:       return UPPER_LAST + CASE_OFFSET;
                    default: return TEXT_W'(UPPER_LAST + CASE_OFFSET + 1);
                endcase
            end
            6:       return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
            default: return TEXT_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [TEXT_W-1:0] flip_case(input logic [TEXT_W-1:0] c);
        if ($urandom_range(1) == 0)
        begin
            return c;
        end
        if (c >= UPPER_FIRST && c <= UPPER_LAST)
        begin
            return c + CASE_OFFSET;
        end
        if (c >= UPPER_FIRST + CASE_OFFSET && c <= UPPER_LAST + CASE_OFFSET)
        begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [TEXT_W-1:0] b, input logic eot);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            text_in.valid <= 1'b0;
            @(negedge clk);
        end
        text_in.valid <= 1'b1;
        text_in.text_byte <= b;
        text_in.end_of_text <= eot;
        do
            @(posedge clk);
        while (!text_in.ready);
        sb.note_byte(b, eot);
        @(negedge clk);
    endtask

    task automatic send_text(input bit closes);
        int i;
        for (i = 0; i < text_buf.size(); i++)
        begin
            send_byte(text_buf[i], closes && (i == text_buf.size() - 1));
        end
    endtask

    task automatic load_text(input string s);
        int i;
        text_buf = {};
        for (i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic wait_idle();
        text_in.valid <= 1'b0;
        while (sb.expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_pattern(input logic [CFG_DATA_W-1:0] low,
                               input logic [CFG_DATA_W-1:0] high,
                               input logic [CFG_DATA_W-1:0] len_word,
                               input logic [CFG_DATA_W-1:0] mode_word);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] value [4];
        int                    k;
        idx[0] = CFG_PATTERN_LOW;
        idx[1] = CFG_PATTERN_HIGH;
        idx[2] = CFG_PATTERN_LEN;
        idx[3] = CFG_OVERLAP_MODE;
        value[0] = low;
        value[1] = high;
        value[2] = len_word;
        value[3] = mode_word;
        for (k = 0; k < 4; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= value[k];
            sb.write_reg(idx[k], value[k]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        logic [2*CFG_DATA_W-1:0] packed_pat;
        logic [CFG_DATA_W-1:0]   len_word;
        int unsigned             sel;
        int unsigned             n;
        int unsigned             cut;
        int unsigned             period;
        int unsigned             i;

        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PATTERN_LOW;
        cfg_data = '0;
        text_in.valid = 1'b0;
        text_in.text_byte = '0;
        text_in.end_of_text = 1'b0;
        result_out.ready = 1'b0;
        steady = 1'b0;
        random_bytes = 0;
        settings = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Default configuration: a zero byte matches the all-zero pattern.
        send_byte(8'h00, 1'b1);
        wait_idle();

        set_pattern(64'h0000_0000_0061_4261, 64'h0, 64'd3, 64'd1);
        load_text("AbAbA");
        send_text(1'b1);
        wait_idle();
        set_pattern(64'h0000_0000_0061_4261, 64'h0, 64'd3, 64'd0);
        load_text("aBaBa");
        send_text(1'b1);
        wait_idle();

        // A length field above the window size acts as the full window.
        set_pattern('1, '1, '1, '1);
        for (i = 0; i < MAX_LEN; i++)
        begin
            send_byte(8'hFF, i == MAX_LEN - 1);
        end
        wait_idle();

        // A zero length acts as one; the bracket characters must not fold.
        set_pattern(64'h5B, 64'h0, 64'd0, 64'd0);
        load_text("[{");
        send_text(1'b1);
        wait_idle();

        // The pattern changes in the middle of a string without clearing the count.
        set_pattern(64'h78, 64'h0, 64'd1, 64'd0);
        send_byte(8'h78, 1'b0);
        wait_idle();
        set_pattern(64'h79, 64'h0, 64'd1, 64'd0);
        load_text("xY");
        send_text(1'b1);
        wait_idle();

        set_pattern(64'h61, 64'h0, 64'd1, 64'd1);
        for (i = 0; i < LONG_RUN_BYTES; i++)
        begin
            send_byte(flip_case(8'h61), i == LONG_RUN_BYTES - 1);
        end
        wait_idle();

        while (random_bytes < RANDOM_BYTES)
        begin
            sel = $urandom_range(19);
            if (sel < 12)
            begin
                pattern_size = $urandom_range(4, 1);
            end
            else if (sel < 16)
            begin
                pattern_size = $urandom_range(8, 5);
            end
            else if (sel < 18)
            begin
                pattern_size = $urandom_range(16, 9);
            end
            else if (sel == 18)
            begin
                pattern_size = 1;
            end
            else
            begin
                pattern_size = MAX_LEN;
            end
            for (i = 0; i < MAX_LEN; i++)
            begin
                pattern[i] = (i < pattern_size) ? random_char() : TEXT_W'($urandom_range(255));
            end
            if ($urandom_range(3) == 0)
            begin
                period = $urandom_range(2, 1);
                for (i = period; i < pattern_size; i++)
                begin
                    pattern[i] = pattern[i % period];
                end
            end
            for (i = 0; i < MAX_LEN; i++)
            begin
                packed_pat[i*TEXT_W +: TEXT_W] = pattern[i];
            end
            len_word = {$urandom(), $urandom()};
            if (sel == 18)
            begin
                len_word[LEN_REG_W-1:0] = '0;
            end
            else if (sel == 19)
            begin
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(31, MAX_LEN));
            end
            else
            begin
                len_word[LEN_REG_W-1:0] = LEN_REG_W'(pattern_size);
            end
            set_pattern(packed_pat[CFG_DATA_W-1:0], packed_pat[2*CFG_DATA_W-1:CFG_DATA_W],
                        len_word, {$urandom(), $urandom()});
            steady = (random_bytes >= 200 && random_bytes < 330);

            repeat ($urandom_range(4, 1))
            begin
                text_buf = {};
                n = $urandom_range(24, 1);
                while (text_buf.size() < n)
                begin
                    sel = $urandom_range(9);
                    if (sel < 4)
                    begin
                        for (i = 0; i < pattern_size; i++)
                        begin
                            text_buf.push_back(flip_case(pattern[i]));
                        end
                    end
                    else if (sel == 4)
                    begin
                        cut = $urandom_range(pattern_size - 1);
                        for (i = 0; i < cut; i++)
                        begin
                            text_buf.push_back(flip_case(pattern[i]));
                        end
                    end
                    else if (sel == 5)
                    begin
                        text_buf.push_back(TEXT_W'($urandom_range(255)));
                    end
                    else if (sel < 8)
                    begin
                        text_buf.push_back(flip_case(pattern[$urandom_range(pattern_size - 1)]));
                    end
                    else
                    begin
                        text_buf.push_back(random_char());
                    end
                end
                // Now and then a string stays open across the next pattern change.
                send_text($urandom_range(9) != 0);
                random_bytes += text_buf.size();
            end
            wait_idle();
        end
        steady = 1'b0;

        $display("Checked %0d results over %0d strings; %0d of them ended a counted match.",
                 sb.results, sb.strings, sb.hits);
        $display("Used %0d pattern settings in both counting modes; the count %s saturation.",
                 settings, sb.saturated ? "reached" : "never reached");
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
